// File: design/ogd_pkg.sv
// shared constants and types for the occupancy grid downsampler
package ogd_pkg;

   localparam int MAX_MAP_WIDTH = 1024;
   localparam int CELL_PIXELS   = 4;
   localparam int CELL_BITS     = $clog2(CELL_PIXELS);
   localparam int DIM_BITS      = $clog2(MAX_MAP_WIDTH) + 1;
   localparam int COUNT_BITS    = $clog2(MAX_MAP_WIDTH);
   localparam int FLAG_DEPTH    = MAX_MAP_WIDTH / CELL_PIXELS;
   localparam int GRID_BITS     = $clog2(FLAG_DEPTH);
   localparam int OUT_BITS      = 8;
   localparam int COLOR_BITS    = 8;

   localparam logic [DIM_BITS-1:0] DIM_RESET = DIM_BITS'(MAX_MAP_WIDTH);
   localparam logic [DIM_BITS-1:0] DIM_MIN   = DIM_BITS'(CELL_PIXELS);
   localparam logic [DIM_BITS-1:0] DIM_MAX   = DIM_BITS'(MAX_MAP_WIDTH);

   localparam logic CSR_MAP_WIDTH  = 1'b0;
   localparam logic CSR_MAP_HEIGHT = 1'b1;

   typedef struct packed {
      logic                 in_cell;
      logic                 cell_start;
      logic                 cell_end;
      logic                 grid_last;
      logic                 pixel_free;
      logic [GRID_BITS-1:0] grid_col;
      logic [GRID_BITS-1:0] grid_row;
   } scan_type;

   function automatic logic [DIM_BITS-1:0] clamp_dim(input logic [DIM_BITS-1:0] v);
      logic [DIM_BITS-1:0] r;
      if (v < DIM_MIN) begin
         r = DIM_MIN;
      end else if (v > DIM_MAX) begin
         r = DIM_MAX;
      end else begin
         r = v;
      end
      return r;
   endfunction

endpackage

// File: design/ogd_ram.sv
// generic single-write single-read ram with registered read
module ogd_ram #(
   parameter int WIDTH = 1,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ogd_scan.sv
// raster position counters and per-pixel cell decode
module ogd_scan
   import ogd_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  logic [DIM_BITS-1:0]   map_width,
   input  logic [DIM_BITS-1:0]   map_height,
   input  logic [COLOR_BITS-1:0] red,
   input  logic [COLOR_BITS-1:0] green,
   input  logic [COLOR_BITS-1:0] blue,
   output scan_type              scan
);

   logic [COUNT_BITS-1:0] col_ff, col_in;
   logic [COUNT_BITS-1:0] row_ff, row_in;
   logic [DIM_BITS-1:0]   width_eff;
   logic [DIM_BITS-1:0]   height_eff;
   logic [GRID_BITS:0]    grid_cols;
   logic [GRID_BITS:0]    grid_rows;
   logic [GRID_BITS:0]    gc_wide;
   logic [GRID_BITS:0]    gr_wide;
   logic [CELL_BITS-1:0]  cx;
   logic [CELL_BITS-1:0]  ry;
   logic [DIM_BITS-1:0]   col_next;
   logic [DIM_BITS-1:0]   row_next;

   always_comb begin
      width_eff  = clamp_dim(map_width);
      height_eff = clamp_dim(map_height);
      grid_cols  = width_eff[DIM_BITS-1:CELL_BITS];
      grid_rows  = height_eff[DIM_BITS-1:CELL_BITS];
      gc_wide    = {1'b0, col_ff[COUNT_BITS-1:CELL_BITS]};
      gr_wide    = {1'b0, row_ff[COUNT_BITS-1:CELL_BITS]};
      cx         = col_ff[CELL_BITS-1:0];
      ry         = row_ff[CELL_BITS-1:0];

      scan.in_cell    = (gc_wide < grid_cols) && (gr_wide < grid_rows);
      scan.cell_start = (cx == '0) && (ry == '0);
      scan.cell_end   = (cx == '1) && (ry == '1);
      scan.grid_last  = (gc_wide == grid_cols - 1'b1) && (gr_wide == grid_rows - 1'b1);
      scan.pixel_free = |(red | green | blue);
      scan.grid_col   = gc_wide[GRID_BITS-1:0];
      scan.grid_row   = gr_wide[GRID_BITS-1:0];

      col_next = {1'b0, col_ff} + 1'b1;
      row_next = {1'b0, row_ff} + 1'b1;
      col_in   = col_ff;
      row_in   = row_ff;
      if (advance) begin
         if (col_next >= width_eff) begin
            col_in = '0;
            if (row_next >= height_eff) begin
               row_in = '0;
            end else begin
               row_in = row_next[COUNT_BITS-1:0];
            end
         end else begin
            col_in = col_next[COUNT_BITS-1:0];
            if ({1'b0, row_ff} >= height_eff) begin
               row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

endmodule

// File: design/occupancy_grid_downsample_core.sv
// occupancy grid downsampler top level: config, flag memory, update stage, output
// a result passes the update stage register, then the rsp output register, after its closing pixel request is accepted
// throughput: one pixel request per cycle while rsp is not stalled, set by the single flag memory read-modify-write
// a write to the same flag entry in the update stage is forwarded to the next read
// reset: pixel counters cleared, map_width and map_height set to 1024
// reset: the column flag memory is not cleared; each cell's first pixel overwrites its entry
module occupancy_grid_downsample_core
   import ogd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [23:0]         req_tdata,  // red, green, blue
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [23:0]         rsp_tdata,  // cell_row, cell_col, blocked, zero fill
   output logic                rsp_tlast,  // last_cell
   input  logic                csr_valid,
   output logic                csr_ready,
   input  logic                csr_index,
   input  logic [DIM_BITS-1:0] csr_data
);

   logic [DIM_BITS-1:0]  map_width_ff, map_width_in;
   logic [DIM_BITS-1:0]  map_height_ff, map_height_in;
   scan_type             scan;
   scan_type             s1_ff;
   logic                 s1_valid_ff, s1_valid_in;
   logic                 fwd_hit_ff, fwd_hit_in;
   logic                 fwd_val_ff;
   logic                 req_accept;
   logic                 s1_fire;
   logic                 out_free;
   logic                 s1_has_result;
   logic                 prev_free;
   logic                 flag;
   logic                 ram_wr_en;
   logic [0:0]           ram_rd_data;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [OUT_BITS-1:0]  rsp_row_ff;
   logic [OUT_BITS-1:0]  rsp_col_ff;
   logic                 rsp_blocked_ff;
   logic                 rsp_last_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      map_width_in  = map_width_ff;
      map_height_in = map_height_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_MAP_WIDTH:  map_width_in  = csr_data;
            CSR_MAP_HEIGHT: map_height_in = csr_data;
            default:        map_width_in  = map_width_ff;
         endcase
      end
   end

   ogd_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .advance    (req_accept),
      .map_width  (map_width_ff),
      .map_height (map_height_ff),
      .red        (req_tdata[7:0]),
      .green      (req_tdata[15:8]),
      .blue       (req_tdata[23:16]),
      .scan       (scan)
   );

   ogd_ram #(
      .WIDTH (1),
      .DEPTH (FLAG_DEPTH)
   ) u_flags (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (s1_ff.grid_col),
      .wr_data (flag),
      .rd_en   (req_accept),
      .rd_addr (scan.grid_col),
      .rd_data (ram_rd_data)
   );

   always_comb begin
      out_free      = !rsp_valid_ff || rsp_tready;
      s1_has_result = s1_ff.in_cell && s1_ff.cell_end;
      s1_fire       = s1_valid_ff && (!s1_has_result || out_free);
      req_tready    = !s1_valid_ff || s1_fire;
      req_accept    = req_tvalid && req_tready;

      prev_free = fwd_hit_ff ? fwd_val_ff : ram_rd_data[0];
      flag      = s1_ff.cell_start ? s1_ff.pixel_free : (prev_free && s1_ff.pixel_free);
      ram_wr_en = s1_fire && s1_ff.in_cell;

      fwd_hit_in  = ram_wr_en && (s1_ff.grid_col == scan.grid_col);
      s1_valid_in = req_accept ? 1'b1 : (s1_fire ? 1'b0 : s1_valid_ff);

      if (s1_fire && s1_has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         map_width_ff  <= DIM_RESET;
         map_height_ff <= DIM_RESET;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         map_width_ff  <= map_width_in;
         map_height_ff <= map_height_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         s1_ff      <= scan;
         fwd_hit_ff <= fwd_hit_in;
         fwd_val_ff <= flag;
      end
      if (s1_fire && s1_has_result) begin
         rsp_row_ff     <= OUT_BITS'(s1_ff.grid_row);
         rsp_col_ff     <= OUT_BITS'(s1_ff.grid_col);
         rsp_blocked_ff <= !flag;
         rsp_last_ff    <= s1_ff.grid_last;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'b0, rsp_blocked_ff, rsp_col_ff, rsp_row_ff};
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: dv/ogd_cell_checker.sv
`timescale 1ns / 1ps
// occupancy grid downsampler checker: watches the channels, predicts cell results, compares
module ogd_cell_checker
   import ogd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tready,
   input  logic [23:0]         req_tdata,  // red, green, blue
   input  logic                rsp_tvalid,
   input  logic                rsp_tready,
   input  logic [23:0]         rsp_tdata,  // cell_row, cell_col, blocked, zero fill
   input  logic                rsp_tlast,  // last_cell
   input  logic                csr_valid,
   input  logic                csr_ready,
   input  logic                csr_index,
   input  logic [DIM_BITS-1:0] csr_data,
   output int                  error_count,
   output int                  cells_pending
);

   typedef struct packed {
      logic [OUT_BITS-1:0] grid_row;
      logic [OUT_BITS-1:0] grid_col;
      logic                blocked;
      logic                final_cell;
   } cell_result_type;

   cell_result_type       cells_due[$];
   cell_result_type       due;
   logic [DIM_BITS-1:0]   width_reg;
   logic [DIM_BITS-1:0]   height_reg;
   logic [FLAG_DEPTH-1:0] free_flags;
   int                    pixel_col;
   int                    pixel_row;

   function automatic int limit_dim(input logic [DIM_BITS-1:0] v);
      return (v < CELL_PIXELS) ? CELL_PIXELS : (v > MAX_MAP_WIDTH) ? MAX_MAP_WIDTH : int'(v);
   endfunction

   task automatic predict_cell(input logic [23:0] pixel);
      int              width_px;
      int              height_px;
      int              gc;
      int              gr;
      logic            pixel_free;
      logic            flag;
      cell_result_type result;
      width_px   = limit_dim(width_reg);
      height_px  = limit_dim(height_reg);
      gc         = pixel_col / CELL_PIXELS;
      gr         = pixel_row / CELL_PIXELS;
      pixel_free = (pixel != '0);
      if (gc < width_px / CELL_PIXELS && gr < height_px / CELL_PIXELS) begin
         if (pixel_col % CELL_PIXELS == 0 && pixel_row % CELL_PIXELS == 0) begin
            flag = pixel_free;
         end else begin
            flag = free_flags[gc] & pixel_free;
         end
         free_flags[gc] = flag;
         if (pixel_col % CELL_PIXELS == CELL_PIXELS - 1 &&
             pixel_row % CELL_PIXELS == CELL_PIXELS - 1) begin
            result.grid_row   = OUT_BITS'(gr);
            result.grid_col   = OUT_BITS'(gc);
            result.blocked    = ~flag;
            result.final_cell = (gc == width_px / CELL_PIXELS - 1) &&
                                (gr == height_px / CELL_PIXELS - 1);
            cells_due.insert(cells_due.size(), result);
         end
      end
      // short rows and a shrunken height both restart the count
      if (pixel_col + 1 >= width_px) begin
         pixel_col = 0;
         pixel_row = (pixel_row + 1 >= height_px) ? 0 : pixel_row + 1;
      end else begin
         pixel_col = pixel_col + 1;
         if (pixel_row >= height_px) begin
            pixel_row = 0;
         end
      end
   endtask

   task automatic flag_field(input string name, input logic [OUT_BITS-1:0] want,
                             input logic [OUT_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0d got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         width_reg   = DIM_RESET;
         height_reg  = DIM_RESET;
         pixel_col   = 0;
         pixel_row   = 0;
         error_count = 0;
         cells_due.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MAP_WIDTH) begin
               width_reg = csr_data;
            end else begin
               height_reg = csr_data;
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (cells_due.size() == 0) begin
               $display("%0t: cell row %0d col %0d arrived with none expected",
                        $time, rsp_tdata[OUT_BITS-1:0], rsp_tdata[2*OUT_BITS-1:OUT_BITS]);
               error_count++;
            end else begin
               due = cells_due.pop_front();
               flag_field("cell_row", due.grid_row, rsp_tdata[OUT_BITS-1:0]);
               flag_field("cell_col", due.grid_col, rsp_tdata[2*OUT_BITS-1:OUT_BITS]);
               flag_field("blocked", OUT_BITS'(due.blocked),
                          OUT_BITS'(rsp_tdata[2*OUT_BITS]));
               flag_field("last_cell", OUT_BITS'(due.final_cell), OUT_BITS'(rsp_tlast));
            end
         end
         if (req_tvalid && req_tready) begin
            predict_cell(req_tdata);
         end
      end
      cells_pending = cells_due.size();
   end

endmodule

// File: dv/occupancy_grid_downsample_core_test.sv
`timescale 1ns / 1ps
// occupancy grid downsampler testbench top: clock, reset, pixel stimulus and verdict
module occupancy_grid_downsample_core_test;
   import ogd_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int PIXEL_TARGET   = 1150;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata  = '0;  // red, green, blue
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b1;
   logic [23:0]         rsp_tdata;        // cell_row, cell_col, blocked, zero fill
   logic                rsp_tlast;        // last_cell
   logic                csr_valid  = 1'b0;
   logic                csr_ready;
   logic                csr_index  = CSR_MAP_WIDTH;
   logic [DIM_BITS-1:0] csr_data   = '0;

   int                    error_count;
   int                    cells_pending;
   int                    send_idle_pct = 0;
   int                    stall_pct     = 0;
   int                    quiet_cycles  = 0;
   int                    pixels_sent   = 0;
   int                    mirror_col    = 0;
   int                    mirror_row    = 0;
   int                    mirror_w      = MAX_MAP_WIDTH;
   int                    mirror_h      = MAX_MAP_WIDTH;
   logic [FLAG_DEPTH-1:0] touched_cols  = '0;

   logic [23:0] free_pixels [16] = '{
      24'hFFFFFF, 24'h000001, 24'h000080, 24'h0000FF, 24'h000100, 24'h008000,
      24'h00FF00, 24'h010000, 24'h800000, 24'hFF0000, 24'h7F7F7F, 24'h808080,
      24'h555555, 24'hAAAAAA, 24'h0F0F0F, 24'hF0F0F0
   };

   occupancy_grid_downsample_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ogd_cell_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tlast     (rsp_tlast),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .error_count   (error_count),
      .cells_pending (cells_pending)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("occupancy_grid_downsample_core: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // out-of-range register values saturate to the bounds
   function automatic logic [DIM_BITS-1:0] raw_for(input int eff);
      if (eff == CELL_PIXELS && $urandom_range(1)) begin
         return DIM_BITS'($urandom_range(CELL_PIXELS - 1));
      end
      if (eff == MAX_MAP_WIDTH && $urandom_range(1)) begin
         return DIM_BITS'($urandom_range(2 ** DIM_BITS - 1, MAX_MAP_WIDTH + 1));
      end
      return DIM_BITS'(eff);
   endfunction

   task automatic write_reg(input logic idx, input logic [DIM_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
   endtask

   task automatic program_dims(input int eff_w, input int eff_h);
      logic [DIM_BITS-1:0] raw_w;
      logic [DIM_BITS-1:0] raw_h;
      raw_w = raw_for(eff_w);
      raw_h = raw_for(eff_h);
      if ($urandom_range(1)) begin
         write_reg(CSR_MAP_WIDTH, raw_w);
         write_reg(CSR_MAP_HEIGHT, raw_h);
      end else begin
         write_reg(CSR_MAP_HEIGHT, raw_h);
         write_reg(CSR_MAP_WIDTH, raw_w);
      end
      csr_valid <= 1'b0;
      mirror_w = eff_w;
      mirror_h = eff_h;
   endtask

   task automatic send_pixel(input logic [23:0] pixel);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= pixel;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      pixels_sent++;
      // track which line store entries hold a written flag
      if (mirror_col / CELL_PIXELS < mirror_w / CELL_PIXELS &&
          mirror_row / CELL_PIXELS < mirror_h / CELL_PIXELS) begin
         touched_cols[mirror_col / CELL_PIXELS] = 1'b1;
      end
      if (mirror_col + 1 >= mirror_w) begin
         mirror_col = 0;
         mirror_row = (mirror_row + 1 >= mirror_h) ? 0 : mirror_row + 1;
      end else begin
         mirror_col = mirror_col + 1;
         if (mirror_row >= mirror_h) begin
            mirror_row = 0;
         end
      end
   endtask

   initial begin
      int          eff_w;
      int          eff_h;
      int          count;
      int          phase;
      logic        safe;
      logic [23:0] pixel;

      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // single-cell frames: a free cell of extreme colors, then one blocked at its last pixel
      program_dims(CELL_PIXELS, CELL_PIXELS);
      foreach (free_pixels[i]) begin
         send_pixel(free_pixels[i]);
      end
      for (int i = 0; i < CELL_PIXELS * CELL_PIXELS; i++) begin
         send_pixel((i == CELL_PIXELS * CELL_PIXELS - 1) ? 24'h000000 :
                    24'($urandom_range(24'hFFFFFF, 1)));
      end
      req_tvalid <= 1'b0;

      phase = 0;
      while (pixels_sent < PIXEL_TARGET) begin
         while (cells_pending != 0) @(negedge clock);
         repeat (DRAIN_CYCLES) @(negedge clock);

         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 74; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 74; end
            default: begin send_idle_pct = 23; stall_pct = 23; end
         endcase

         case ($urandom_range(9))
            0: eff_w = CELL_PIXELS;
            1: eff_w = MAX_MAP_WIDTH;
            2: eff_w = $urandom_range(MAX_MAP_WIDTH - 1, 25);
            default: eff_w = $urandom_range(24, CELL_PIXELS + 1);
         endcase
         case ($urandom_range(9))
            0: eff_h = CELL_PIXELS;
            1: eff_h = MAX_MAP_WIDTH;
            2: eff_h = $urandom_range(64, 13);
            default: eff_h = $urandom_range(12, CELL_PIXELS + 1);
         endcase

         // a change mid-frame must not make the block read a flag never written
         safe = (mirror_col == 0 && mirror_row % CELL_PIXELS == 0 && mirror_row < eff_h);
         if (!safe) begin
            safe = 1'b1;
            for (int i = 0; i < eff_w / CELL_PIXELS; i++) begin
               if (!touched_cols[i]) begin
                  safe = 1'b0;
               end
            end
         end
         if (!safe) begin
            eff_w = mirror_w;
            eff_h = mirror_h;
         end
         program_dims(eff_w, eff_h);

         // often run to the end of the frame so that later phases start clean
         count = $urandom_range(90, 10);
         if (mirror_row < mirror_h && mirror_col < mirror_w && $urandom_range(1)) begin
            count = (mirror_h - mirror_row - 1) * mirror_w + mirror_w - mirror_col;
            if (count > 260) begin
               count = $urandom_range(90, 10);
            end
         end
         if (count > PIXEL_TARGET - pixels_sent) begin
            count = PIXEL_TARGET - pixels_sent;
         end

         repeat (count) begin
            case ($urandom_range(23))
               0:       pixel = '0;
               1, 2:    pixel = 24'(1) << $urandom_range(23);
               3, 4:    pixel = 24'($urandom_range(255)) << (8 * $urandom_range(2));
               default: pixel = 24'($urandom);
            endcase
            send_pixel(pixel);
         end
         req_tvalid <= 1'b0;
         phase++;
      end

      stall_pct = 0;
      while (cells_pending != 0) @(negedge clock);
      repeat (4 * DRAIN_CYCLES) @(negedge clock);
      if (error_count == 0) begin
         $display("occupancy_grid_downsample_core: match");
      end else begin
         $display("occupancy_grid_downsample_core: mismatch");
      end
      $finish;
   end

endmodule

// File: files.f
design/ogd_pkg.sv
design/ogd_ram.sv
design/ogd_scan.sv
design/occupancy_grid_downsample_core.sv
dv/ogd_cell_checker.sv
dv/occupancy_grid_downsample_core_test.sv
